// ===== rtl/elevator_door_controller_assert.svh =====
// Assertion macros shared by the checker of the elevator door controller.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ELEVATOR_DOOR_CONTROLLER_ASSERT_SVH
`define ELEVATOR_DOOR_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elevator door controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define EDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elevator door controller check failed");

`endif

// ===== rtl/edc_pkg.sv =====
package edc_pkg;

  // Car modes as they appear on the result channel.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_UP    = 3'd1;
  localparam logic [2:0] MODE_DOWN  = 3'd2;
  localparam logic [2:0] MODE_OPEN  = 3'd3;
  localparam logic [2:0] MODE_CLOSE = 3'd4;
  localparam logic [2:0] MODE_OBST  = 3'd5;
  localparam logic [2:0] MODE_FAULT = 3'd6;

  // Key codes.
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_CLEAR     = 4'd10;
  localparam logic [3:0] KEY_CONFIRM   = 4'd11;

  // Action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KEY  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MS         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_OPEN_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_CLOSE_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_POLL_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_POLL_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_MS        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned LIGHT_W    = 10;
  localparam int unsigned FLOOR_W    = 7;

  // Reset values of the configuration registers.
  localparam logic [DUR_W-1:0]   MOVE_MS_RST         = 16'd1000;
  localparam logic [DUR_W-1:0]   DOOR_OPEN_MS_RST    = 16'd3000;
  localparam logic [DUR_W-1:0]   DOOR_CLOSE_MS_RST   = 16'd2000;
  localparam logic [DUR_W-1:0]   CLOSE_POLL_MS_RST   = 16'd50;
  localparam logic [DUR_W-1:0]   CLEAR_POLL_MS_RST   = 16'd100;
  localparam logic [DUR_W-1:0]   FAULT_MS_RST        = 16'd2000;
  localparam logic [LIGHT_W-1:0] LIGHT_THRESHOLD_RST = 10'd400;

  // Bus bytes sent to the buzzer.
  localparam logic BUS_OBSTACLE = 1'b1;
  localparam logic BUS_CLEAR    = 1'b0;

  typedef struct packed {
    logic               action;
    logic [3:0]         key_code;
    logic [LIGHT_W-1:0] light_level;
  } in_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [FLOOR_W-1:0] floor;
    logic [FLOOR_W-1:0] entered_floor;
    logic               ready_lamp;
    logic               moving_lamp;
    logic               door_lamp;
    logic               bus_send;
    logic               bus_command;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [DUR_W-1:0]   move_ms;
    logic [DUR_W-1:0]   door_open_ms;
    logic [DUR_W-1:0]   door_close_ms;
    logic [DUR_W-1:0]   close_poll_ms;
    logic [DUR_W-1:0]   clear_poll_ms;
    logic [DUR_W-1:0]   fault_ms;
    logic [LIGHT_W-1:0] light_threshold;
  } cfg_t;

  // Status shown with every result of one item.
  typedef struct packed {
    logic [2:0]         mode;
    logic [FLOOR_W-1:0] floor;
    logic [FLOOR_W-1:0] entered_floor;
    logic               ready_lamp;
    logic               moving_lamp;
    logic               door_lamp;
  } status_t;

  // All results of one item: the status, the number of bus bytes ahead of the
  // final status result and the byte value, which is the same for all of them.
  typedef struct packed {
    status_t    status;
    logic [1:0] nbytes;
    logic       cmd;
  } bundle_t;

endpackage

// ===== rtl/edc_cfg.sv =====
module edc_cfg (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [edc_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [edc_pkg::CFG_DATA_W-1:0]            cfg_data,
  output edc_pkg::cfg_t                             cfg
);

  edc_pkg::cfg_t cfg_r;
  logic [edc_pkg::DUR_W-1:0] dur_wr;

  // A duration of zero is stored as one.
  assign dur_wr = (cfg_data == '0) ? edc_pkg::DUR_W'(1) : cfg_data;
  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_ms         <= edc_pkg::MOVE_MS_RST;
      cfg_r.door_open_ms    <= edc_pkg::DOOR_OPEN_MS_RST;
      cfg_r.door_close_ms   <= edc_pkg::DOOR_CLOSE_MS_RST;
      cfg_r.close_poll_ms   <= edc_pkg::CLOSE_POLL_MS_RST;
      cfg_r.clear_poll_ms   <= edc_pkg::CLEAR_POLL_MS_RST;
      cfg_r.fault_ms        <= edc_pkg::FAULT_MS_RST;
      cfg_r.light_threshold <= edc_pkg::LIGHT_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        edc_pkg::CFG_MOVE_MS:         cfg_r.move_ms       <= dur_wr;
        edc_pkg::CFG_DOOR_OPEN_MS:    cfg_r.door_open_ms  <= dur_wr;
        edc_pkg::CFG_DOOR_CLOSE_MS:   cfg_r.door_close_ms <= dur_wr;
        edc_pkg::CFG_CLOSE_POLL_MS:   cfg_r.close_poll_ms <= dur_wr;
        edc_pkg::CFG_CLEAR_POLL_MS:   cfg_r.clear_poll_ms <= dur_wr;
        edc_pkg::CFG_FAULT_MS:        cfg_r.fault_ms      <= dur_wr;
        edc_pkg::CFG_LIGHT_THRESHOLD: begin
          cfg_r.light_threshold <= cfg_data[edc_pkg::LIGHT_W-1:0];
        end
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

endmodule

// ===== rtl/edc_core.sv =====
module edc_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  edc_pkg::in_t     in_item,
  input  edc_pkg::cfg_t    cfg,
  output edc_pkg::bundle_t bundle
);

  localparam int unsigned TB = TIMER_BITS;
  localparam int unsigned WW = (TB > edc_pkg::DUR_W) ? TB : edc_pkg::DUR_W;
  localparam logic [TB-1:0] TMAX = '1;
  localparam logic [2:0] LAMP_READY  = 3'b001;
  localparam logic [2:0] LAMP_MOVING = 3'b010;
  localparam logic [2:0] LAMP_DOOR   = 3'b100;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_UP    = 3'd1,
    ST_DOWN  = 3'd2,
    ST_OPEN  = 3'd3,
    ST_CLOSE = 3'd4,
    ST_OBST  = 3'd5,
    ST_FAULT = 3'd6
  } state_t;

  localparam int unsigned FW = edc_pkg::FLOOR_W;

  state_t          mode_r, mode_nxt;
  logic [FW-1:0]   car_r, car_nxt;
  logic [FW-1:0]   goal_r, goal_nxt;
  logic [FW-1:0]   typed_r, typed_nxt;
  logic [TB-1:0]   phase_r, phase_nxt;
  logic [TB-1:0]   poll_r, poll_nxt;
  logic [2:0]      lamp_r, lamp_nxt;
  logic [1:0]      nbytes;
  logic            cmd;
  logic            dark;
  logic [TB-1:0]   phase_inc, poll_inc, phase_add;
  logic [TB:0]     phase_sum;
  logic [TB-1:0]   dur_move, dur_open, dur_close, dur_cpoll, dur_xpoll, dur_fault;

  // Durations longer than the timer are capped at its largest value.
  function automatic logic [TB-1:0] cap(input logic [edc_pkg::DUR_W-1:0] d);
    logic [WW-1:0] w;
    w = WW'(d);
    return (w > WW'(TMAX)) ? TMAX : TB'(w);
  endfunction

  assign dur_move  = cap(cfg.move_ms);
  assign dur_open  = cap(cfg.door_open_ms);
  assign dur_close = cap(cfg.door_close_ms);
  assign dur_cpoll = cap(cfg.close_poll_ms);
  assign dur_xpoll = cap(cfg.clear_poll_ms);
  assign dur_fault = cap(cfg.fault_ms);

  assign dark      = in_item.light_level < cfg.light_threshold;
  assign phase_inc = (phase_r == TMAX) ? TMAX : phase_r + TB'(1);
  assign poll_inc  = (poll_r == TMAX) ? TMAX : poll_r + TB'(1);
  assign phase_sum = {1'b0, phase_r} + {1'b0, dur_cpoll};
  assign phase_add = phase_sum[TB] ? TMAX : phase_sum[TB-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    car_nxt   = car_r;
    goal_nxt  = goal_r;
    typed_nxt = typed_r;
    phase_nxt = phase_r;
    poll_nxt  = poll_r;
    lamp_nxt  = lamp_r;
    nbytes    = 2'd0;
    cmd       = edc_pkg::BUS_CLEAR;
    if (in_item.action == edc_pkg::ACT_KEY) begin
      if (mode_r == ST_IDLE) begin
        if (in_item.key_code <= edc_pkg::KEY_DIGIT_MAX) begin
          if (typed_r <= FW'(edc_pkg::KEY_DIGIT_MAX)) begin
            typed_nxt = FW'(typed_r * FW'(10)) + FW'(in_item.key_code);
          end
        end else if (in_item.key_code == edc_pkg::KEY_CLEAR) begin
          typed_nxt = '0;
        end else if (in_item.key_code == edc_pkg::KEY_CONFIRM) begin
          goal_nxt  = typed_r;
          phase_nxt = '0;
          if (typed_r == car_r) begin
            mode_nxt = ST_FAULT;
          end else begin
            lamp_nxt = LAMP_MOVING;
            if (typed_r > car_r) begin
              mode_nxt = ST_UP;
              car_nxt  = car_r + FW'(1);
            end else begin
              mode_nxt = ST_DOWN;
              car_nxt  = car_r - FW'(1);
            end
          end
        end
      end
    end else begin
      unique case (mode_r)
        ST_UP, ST_DOWN: begin
          phase_nxt = phase_inc;
          if (phase_inc >= dur_move) begin
            phase_nxt = '0;
            if (car_r == goal_r) begin
              mode_nxt = ST_OPEN;
              lamp_nxt = lamp_r | LAMP_DOOR;
            end else if (mode_r == ST_UP) begin
              car_nxt = car_r + FW'(1);
            end else begin
              car_nxt = car_r - FW'(1);
            end
          end
        end
        ST_OPEN: begin
          phase_nxt = phase_inc;
          if (phase_inc >= dur_open) begin
            mode_nxt  = ST_CLOSE;
            phase_nxt = '0;
            poll_nxt  = '0;
          end
        end
        ST_CLOSE: begin
          if (poll_r == '0 && dark) begin
            nbytes   = 2'd2;
            cmd      = edc_pkg::BUS_OBSTACLE;
            mode_nxt = ST_OBST;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= dur_cpoll) begin
              poll_nxt  = '0;
              phase_nxt = phase_add;
              if (phase_add >= dur_close) begin
                nbytes    = 2'd1;
                mode_nxt  = ST_IDLE;
                typed_nxt = '0;
                lamp_nxt  = LAMP_READY;
              end
            end
          end
        end
        ST_OBST: begin
          poll_nxt = poll_inc;
          if (poll_inc >= dur_xpoll) begin
            poll_nxt = '0;
            if (!dark) begin
              nbytes    = 2'd1;
              mode_nxt  = ST_OPEN;
              phase_nxt = '0;
              lamp_nxt  = lamp_r | LAMP_DOOR;
            end
          end
        end
        ST_FAULT: begin
          phase_nxt = phase_inc;
          if (phase_inc >= dur_fault) begin
            mode_nxt  = ST_IDLE;
            typed_nxt = '0;
            lamp_nxt  = LAMP_READY;
          end
        end
        ST_IDLE: begin
          // Ticks have no effect while idle.
        end
        default: begin
          mode_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // The results of this item carry the state after the step.
  assign bundle.status.mode          = 3'(mode_nxt);
  assign bundle.status.floor         = car_nxt;
  assign bundle.status.entered_floor = typed_nxt;
  assign bundle.status.ready_lamp    = |(lamp_nxt & LAMP_READY);
  assign bundle.status.moving_lamp   = |(lamp_nxt & LAMP_MOVING);
  assign bundle.status.door_lamp     = |(lamp_nxt & LAMP_DOOR);
  assign bundle.nbytes               = nbytes;
  assign bundle.cmd                  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_IDLE;
      car_r   <= '0;
      goal_r  <= '0;
      typed_r <= '0;
      phase_r <= '0;
      poll_r  <= '0;
      lamp_r  <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      car_r   <= car_nxt;
      goal_r  <= goal_nxt;
      typed_r <= typed_nxt;
      phase_r <= phase_nxt;
      poll_r  <= poll_nxt;
      lamp_r  <= lamp_nxt;
    end
  end

endmodule

// ===== rtl/edc_out.sv =====
module edc_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  edc_pkg::bundle_t bundle,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output edc_pkg::out_t    out_data
);

  edc_pkg::bundle_t bundle_r;
  logic             valid_r;
  logic             is_last;
  logic             xfer;

  assign is_last  = (bundle_r.nbytes == 2'd0);
  assign xfer     = valid_r && !out_stall;
  // Busy unless the final result of the held item leaves in this cycle.
  assign busy     = valid_r && !(xfer && is_last);
  assign out_valid = valid_r;

  assign out_data.mode          = bundle_r.status.mode;
  assign out_data.floor         = bundle_r.status.floor;
  assign out_data.entered_floor = bundle_r.status.entered_floor;
  assign out_data.ready_lamp    = bundle_r.status.ready_lamp;
  assign out_data.moving_lamp   = bundle_r.status.moving_lamp;
  assign out_data.door_lamp     = bundle_r.status.door_lamp;
  assign out_data.bus_send      = !is_last;
  assign out_data.bus_command   = !is_last && bundle_r.cmd;
  assign out_data.last          = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (xfer && is_last) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bundle_r <= bundle;
    end else if (xfer && !is_last) begin
      bundle_r.nbytes <= bundle_r.nbytes - 2'd1;
    end
  end

endmodule

// ===== rtl/elevator_door_controller.sv =====
// Single-car elevator controller with door and light-beam obstacle handling.
// Input channel (in_valid, in_stall, in_data): each transfer is either a
// one millisecond tick with a light sample or a key press. Result channel
// (out_valid, out_stall, out_data): every input item yields one to three
// results; bus byte results (bus_send set) come first and the final status
// result has last set. Configuration (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready; the user must write it only while the block is
// idle, which the block does not enforce. Latency: the first result of an item
// is shown in the cycle after its transfer. Throughput: one item per cycle when
// each item yields a single result and the receiver does not stall; an item
// with bus bytes holds the input until all its results have left, since the
// one output register shows one result per cycle. The next item is taken in
// the same cycle as the final result of the previous one leaves. When the
// receiver stalls, the shown result holds and the input is stalled once that
// result register is occupied. Reset (rst_n low, synchronous) puts the car
// idle at floor zero with all lamps off, clears the typed number and timers,
// and reloads the default durations and light threshold.
module elevator_door_controller #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  edc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output edc_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [edc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  edc_pkg::cfg_t    cfg;
  edc_pkg::bundle_t bundle;
  logic             busy;
  logic             accept;

  // An item transfers when the result register is free or about to free up.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  edc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Mode logic and the car state registers, which take the step when an item is accepted.
  edc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .cfg     (cfg),
    .bundle  (bundle)
  );

  // Result register that walks through the bus bytes and the final status.
  edc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .bundle    (bundle),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/edc_checker.sv =====
`include "elevator_door_controller_assert.svh"

module edc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input edc_pkg::out_t out_data
);

  // A stalled result stays on the port unchanged.
  `EDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Any result that is not the final one carries a bus byte.
  `EDC_ASSERT_SAME(a_nonlast_bus, out_valid && !out_data.last, out_data.bus_send)

  // Once a bus byte leaves, another result of the same item follows at once.
  `EDC_ASSERT_NEXT(a_more_follow, out_valid && !out_data.last && !out_stall, out_valid)

  // The obstacle byte only goes out as the car enters the obstacle mode.
  `EDC_ASSERT_SAME(a_obst_byte, out_valid && out_data.bus_send && out_data.bus_command,
                   out_data.mode == edc_pkg::MODE_OBST)

  // The input is held back only while a result is waiting.
  `EDC_ASSERT_SAME(a_stall_cause, in_stall, out_valid)

endmodule

bind elevator_door_controller edc_checker u_edc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

import edc_pkg::*;

// Tracks the car the same way the controller should and holds the results
// that are still owed on the result channel.
class elevator_scoreboard;
  out_t               due_results[$];
  logic [2:0]         car_mode;
  logic [FLOOR_W-1:0] car_floor;
  logic [FLOOR_W-1:0] goal_floor;
  logic [FLOOR_W-1:0] typed_floor;
  logic [DUR_W-1:0]   phase_ms;
  logic [DUR_W-1:0]   poll_ms;
  logic               lamp_ready;
  logic               lamp_moving;
  logic               lamp_door;
  logic [DUR_W-1:0]   dur_ms[6];
  logic [LIGHT_W-1:0] light_thr;
  int                 errors;

  function new();
    car_mode    = MODE_IDLE;
    car_floor   = '0;
    goal_floor  = '0;
    typed_floor = '0;
    phase_ms    = '0;
    poll_ms     = '0;
    lamp_ready  = 1'b0;
    lamp_moving = 1'b0;
    lamp_door   = 1'b0;
    dur_ms[CFG_MOVE_MS]       = MOVE_MS_RST;
    dur_ms[CFG_DOOR_OPEN_MS]  = DOOR_OPEN_MS_RST;
    dur_ms[CFG_DOOR_CLOSE_MS] = DOOR_CLOSE_MS_RST;
    dur_ms[CFG_CLOSE_POLL_MS] = CLOSE_POLL_MS_RST;
    dur_ms[CFG_CLEAR_POLL_MS] = CLEAR_POLL_MS_RST;
    dur_ms[CFG_FAULT_MS]      = FAULT_MS_RST;
    light_thr   = LIGHT_THRESHOLD_RST;
    errors      = 0;
  endfunction

  // A zero duration is kept as one; indexes past the threshold do nothing.
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_LIGHT_THRESHOLD) begin
      light_thr = data[LIGHT_W-1:0];
    end else if (idx < CFG_LIGHT_THRESHOLD) begin
      dur_ms[idx] = (data == '0) ? 16'd1 : data;
    end
  endfunction

  function logic [DUR_W-1:0] sat_add(logic [DUR_W-1:0] a, logic [DUR_W-1:0] b);
    logic [DUR_W:0] s;
    s = a + b;
    return s[DUR_W] ? '1 : s[DUR_W-1:0];
  endfunction

  function void enter_idle();
    car_mode    = MODE_IDLE;
    typed_floor = '0;
    lamp_ready  = 1'b1;
    lamp_moving = 1'b0;
    lamp_door   = 1'b0;
  endfunction

  function void open_door();
    car_mode  = MODE_OPEN;
    phase_ms  = '0;
    lamp_door = 1'b1;
  endfunction

  // Advances the car by one accepted item and queues the results it owes.
  function void note_item(in_t it);
    logic dark;
    int   nbytes;
    logic cmd;
    out_t r;
    dark   = (it.light_level < light_thr);
    nbytes = 0;
    cmd    = BUS_CLEAR;
    if (it.action == ACT_KEY) begin
      if (car_mode == MODE_IDLE) begin
        if (it.key_code <= KEY_DIGIT_MAX) begin
          if (typed_floor <= 9) typed_floor = typed_floor * 10 + it.key_code;
        end else if (it.key_code == KEY_CLEAR) begin
          typed_floor = '0;
        end else if (it.key_code == KEY_CONFIRM) begin
          goal_floor = typed_floor;
          phase_ms   = '0;
          if (goal_floor == car_floor) begin
            car_mode = MODE_FAULT;
          end else begin
            lamp_ready  = 1'b0;
            lamp_moving = 1'b1;
            lamp_door   = 1'b0;
            if (goal_floor > car_floor) begin
              car_mode  = MODE_UP;
              car_floor = car_floor + 1;
            end else begin
              car_mode  = MODE_DOWN;
              car_floor = car_floor - 1;
            end
          end
        end
      end
    end else begin
      case (car_mode)
        MODE_UP, MODE_DOWN: begin
          phase_ms = sat_add(phase_ms, 1);
          if (phase_ms >= dur_ms[CFG_MOVE_MS]) begin
            phase_ms = '0;
            if (car_floor == goal_floor) open_door();
            else if (car_mode == MODE_UP) car_floor = car_floor + 1;
            else car_floor = car_floor - 1;
          end
        end
        MODE_OPEN: begin
          phase_ms = sat_add(phase_ms, 1);
          if (phase_ms >= dur_ms[CFG_DOOR_OPEN_MS]) begin
            car_mode = MODE_CLOSE;
            phase_ms = '0;
            poll_ms  = '0;
          end
        end
        MODE_CLOSE: begin
          // The beam is only looked at when a poll falls due.
          if (poll_ms == '0 && dark) begin
            nbytes   = 2;
            cmd      = BUS_OBSTACLE;
            car_mode = MODE_OBST;
          end else begin
            poll_ms = sat_add(poll_ms, 1);
            if (poll_ms >= dur_ms[CFG_CLOSE_POLL_MS]) begin
              poll_ms  = '0;
              phase_ms = sat_add(phase_ms, dur_ms[CFG_CLOSE_POLL_MS]);
              if (phase_ms >= dur_ms[CFG_DOOR_CLOSE_MS]) begin
                nbytes = 1;
                enter_idle();
              end
            end
          end
        end
        MODE_OBST: begin
          poll_ms = sat_add(poll_ms, 1);
          if (poll_ms >= dur_ms[CFG_CLEAR_POLL_MS]) begin
            poll_ms = '0;
            if (!dark) begin
              nbytes = 1;
              open_door();
            end
          end
        end
        MODE_FAULT: begin
          phase_ms = sat_add(phase_ms, 1);
          if (phase_ms >= dur_ms[CFG_FAULT_MS]) enter_idle();
        end
        default: ;
      endcase
    end
    r.mode          = car_mode;
    r.floor         = car_floor;
    r.entered_floor = typed_floor;
    r.ready_lamp    = lamp_ready;
    r.moving_lamp   = lamp_moving;
    r.door_lamp     = lamp_door;
    r.bus_send      = 1'b1;
    r.bus_command   = cmd;
    r.last          = 1'b0;
    for (int k = 0; k < nbytes; k++) due_results.push_back(r);
    r.bus_send    = 1'b0;
    r.bus_command = 1'b0;
    r.last        = 1'b1;
    due_results.push_back(r);
  endfunction

  function string show(out_t r);
    return $sformatf("mode=%0d floor=%0d typed=%0d lamps(r/m/d)=%b%b%b bus=%b/%b last=%b",
                     r.mode, r.floor, r.entered_floor, r.ready_lamp, r.moving_lamp,
                     r.door_lamp, r.bus_send, r.bus_command, r.last);
  endfunction

  function void flag(string what, string want, string got);
    errors++;
    if (errors <= 10) $display("%0t %s: want %s; got %s", $time, what, want, got);
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (due_results.size() == 0) begin
      flag("unexpected result", "nothing", show(got));
    end else begin
      want = due_results.pop_front();
      if (got !== want) flag("result mismatch", show(want), show(got));
    end
  endfunction

  function void flush_leftovers();
    while (due_results.size() != 0) flag("missing result", show(due_results.pop_front()), "nothing");
  endfunction
endclass

module tb;
  // Cycles without any transfer on any channel before the run is given up.
  localparam int unsigned QUIET_LIMIT = 1000;
  // Index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 3'd7;
  // Highest code the key field can carry; codes above confirm are unused.
  localparam logic [3:0] KEY_CODE_MAX = 4'd15;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  elevator_scoreboard sb;

  // Sender side: tx_up mirrors what in_valid was last told, so that valid is
  // never lowered and raised within one time step.
  bit tx_up   = 1'b0;
  bit idle_on = 1'b1;
  // Receiver side: rx_calm turns off stalls for a stretch of the run.
  bit rx_calm = 1'b0;
  // The last phase runs with no gaps on either side.
  bit no_idle = 1'b0;
  // With calm set the beam stays clear, so the last phase cannot loop.
  bit calm    = 1'b0;
  int work_items   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  int obst_seen    = 0;
  int obst_cap     = 0;

  elevator_door_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: every transfer is checked against the oldest owed result,
  // then the stall for the next cycle is chosen.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) sb.check_result(out_data);
    if (no_idle || rx_calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: a long stretch with no transfer anywhere means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic lower_input();
    if (tx_up) begin
      in_valid <= 1'b0;
      tx_up = 1'b0;
    end
  endtask

  // Offers one item, sometimes after a gap, and waits for its transfer.
  // Only keys in idle and ticks outside idle count as work.
  task automatic push_item(input in_t it);
    if (idle_on && !no_idle && $urandom_range(0, 5) == 0) begin
      lower_input();
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    tx_up = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if ((it.action == ACT_KEY) == (sb.car_mode == MODE_IDLE)) work_items++;
    sb.note_item(it);
  endtask

  task automatic push_key(input logic [3:0] code);
    in_t it;
    it.action      = ACT_KEY;
    it.key_code    = code;
    it.light_level = $urandom_range(0, 1023);
    push_item(it);
  endtask

  task automatic push_tick(input logic [LIGHT_W-1:0] light);
    in_t it;
    it.action      = ACT_TICK;
    it.key_code    = $urandom_range(0, 15);
    it.light_level = light;
    push_item(it);
  endtask

  // Holds the input back until every owed result has been seen; it always
  // waits on the clock so that valid is not lowered and raised in the same step.
  task automatic hold_until_drained();
    lower_input();
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Reprograms all registers once the block has gone quiet. The threshold
  // write carries junk in its upper bits, which must be dropped, and a write
  // to an index past the list must be ignored.
  task automatic load_settings(input int mv, input int op, input int cl, input int cp,
                               input int clp, input int flt, input int thr);
    hold_until_drained();
    repeat (4) @(posedge clk);
    write_reg(CFG_MOVE_MS, mv);
    write_reg(CFG_DOOR_OPEN_MS, op);
    write_reg(CFG_DOOR_CLOSE_MS, cl);
    write_reg(CFG_CLOSE_POLL_MS, cp);
    write_reg(CFG_CLEAR_POLL_MS, clp);
    write_reg(CFG_FAULT_MS, flt);
    write_reg(CFG_LIGHT_THRESHOLD, thr | ($urandom_range(0, 63) << LIGHT_W));
    write_reg(CFG_NO_SUCH_REG, $urandom_range(0, 65535));
    cfg_valid <= 1'b0;
  endtask

  // While closing, an obstacle is shown now and then, up to a cap per trip;
  // while blocked, the beam clears about half the time. Elsewhere the light
  // is never read, so any sample will do.
  function automatic logic [LIGHT_W-1:0] pick_light();
    logic [LIGHT_W-1:0] thr;
    bit                 want_dark;
    thr = sb.light_thr;
    case (sb.car_mode)
      MODE_CLOSE: want_dark = !calm && obst_seen < obst_cap && $urandom_range(0, 5) == 0;
      MODE_OBST:  want_dark = !calm && $urandom_range(0, 1) == 0;
      default:    return $urandom_range(0, 1023);
    endcase
    if (want_dark && thr != 0) return $urandom_range(0, thr - 1);
    return $urandom_range(thr, 1023);
  endfunction

  // Mostly a few floors away, sometimes anywhere, sometimes the same floor.
  function automatic int pick_target();
    int here;
    int stride;
    here = sb.car_floor;
    case ($urandom_range(0, 9))
      0: return here;
      1: return $urandom_range(0, 99);
      default: begin
        stride = $urandom_range(1, 3);
        if (($urandom_range(0, 1) == 1 && here + stride <= 99) || here < stride)
          return here + stride;
        return here - stride;
      end
    endcase
  endfunction

  // Feeds ticks until the car is back in idle, with the odd key press that
  // the controller must ignore while busy.
  task automatic finish_trip();
    logic [2:0] prev;
    while (sb.car_mode != MODE_IDLE) begin
      if ($urandom_range(0, 24) == 0) begin
        push_key($urandom_range(0, 15));
      end else begin
        prev = sb.car_mode;
        push_tick(pick_light());
        if (prev == MODE_CLOSE && sb.car_mode == MODE_OBST) obst_seen++;
      end
    end
  endtask

  // One call: type a floor (with some noise on the keypad), confirm it and
  // ride it out to idle again.
  task automatic run_trip(input int target);
    obst_seen = 0;
    obst_cap  = $urandom_range(0, 2);
    if (!no_idle) begin
      idle_on = ($urandom_range(0, 2) != 0);
      rx_calm = ($urandom_range(0, 3) == 0);
    end
    repeat ($urandom_range(0, 2)) push_tick($urandom_range(0, 1023));
    if ($urandom_range(0, 3) == 0) begin
      push_key($urandom_range(0, 9));
      push_key(KEY_CLEAR);
    end
    if ($urandom_range(0, 5) == 0) push_key($urandom_range(KEY_CONFIRM + 1, KEY_CODE_MAX));
    if (target >= 10) begin
      push_key(target / 10);
      push_key(target % 10);
      // A third digit must not change a two-digit entry.
      if ($urandom_range(0, 4) == 0) push_key($urandom_range(0, 9));
    end else begin
      if ($urandom_range(0, 2) == 0) push_key(0);
      push_key(target);
    end
    if (!no_idle && $urandom_range(0, 4) == 0) hold_until_drained();
    push_key(KEY_CONFIRM);
    finish_trip();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with the reset state. Ticks in idle at both light
    // extremes must do nothing.
    push_tick(10'd0);
    push_tick(10'd1023);
    // Two nines make 99; the third digit is dropped.
    push_key(9);
    push_key(9);
    push_key(0);
    // Unused codes are ignored, clear wipes the entry.
    push_key(KEY_CONFIRM + 1);
    push_key(KEY_CODE_MAX);
    push_key(KEY_CLEAR);

    // Short timing with a zero fault time, which must act as one.
    load_settings(2, 3, 6, 2, 3, 0, 400);
    // Confirming floor 0 while standing at floor 0 is a fault; a key press
    // during the fault is ignored.
    push_key(0);
    push_key(KEY_CONFIRM);
    push_key(5);
    finish_trip();
    work_items = 0;
    while (work_items < 90) run_trip(pick_target());

    // Shortest timing and the highest threshold; run to the top floor.
    load_settings(0, 1, 1, 0, 1, 1, 1023);
    run_trip(99);
    while (work_items < 180) run_trip(pick_target());

    // A close time that is not a whole number of polls, and a zero
    // threshold, so the beam can never be blocked.
    load_settings(3, 2, 10, 3, 2, 4, 0);
    while (work_items < 260) run_trip(pick_target());

    // Last part: no gaps on either side, one fault and a one-floor trip.
    no_idle = 1'b1;
    rx_calm = 1'b1;
    calm    = 1'b1;
    load_settings(2, 4, 8, 3, 2, 5, 1);
    run_trip(sb.car_floor);
    run_trip(sb.car_floor == 99 ? 98 : sb.car_floor + 1);

    hold_until_drained();
    repeat (8) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
